>>> src/mnst_pkg.sv
package mnst_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned TICK_HZ_W = 20;
    localparam int unsigned CYC_HZ_W  = 34;
    localparam int unsigned MUL_W     = 30;
    localparam int unsigned DIV_W     = CYC_HZ_W;
    localparam int unsigned HALF_W    = DATA_W / 2;
    localparam int unsigned PP_W      = HALF_W + MUL_W;
    localparam int unsigned PROD_W    = DATA_W + MUL_W;
    localparam int unsigned DIV_STEPS = PROD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [MUL_W-1:0] NS_PER_SEC = MUL_W'(1000000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED    = 2'd0,
        REG_TICK_HZ    = 2'd1,
        REG_CYCLE_HZ   = 2'd2,
        REG_CYCLE_BASE = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_DIV,
        S_CLAMP,
        S_RAISE,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OP_CYCLE,
        OP_TICK,
        OP_DERIVE
    } t_op_sel;

    typedef struct packed {
        logic    capture;
        logic    tick;
        logic    load_op;
        t_op_sel op_sel;
        logic    zero_q;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_sum;
        logic    div_step;
        logic    clamp;
        logic    raise;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_read;
        logic enabled;
        logic cycle_hz_nz;
        logic tick_hz_nz;
        logic div_last;
    } t_dp_status;

endpackage

>>> src/mnst_ctrl.sv
module mnst_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_m_ready,
    input  mnst_pkg::t_dp_status i_status,
    output mnst_pkg::t_dp_cmd    o_cmd,
    output logic                 o_s_ready,
    output logic                 o_m_valid
);
    import mnst_pkg::*;

    t_state    r_state, n_state;
    logic      r_phase, n_phase;
    logic      r_out_valid, n_out_valid;
    t_dp_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        cmd       = '0;
        o_s_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_status.cmd_read) begin
                    cmd.tick = 1'b1;
                    n_state  = S_FINISH;
                end else if (!i_status.enabled) begin
                    n_state = S_FINISH;
                end else if (i_status.cycle_hz_nz) begin
                    cmd.load_op = 1'b1;
                    cmd.op_sel  = OP_CYCLE;
                    n_phase     = 1'b0;
                    n_state     = S_MUL_LO;
                end else if (i_status.tick_hz_nz) begin
                    cmd.load_op = 1'b1;
                    cmd.op_sel  = OP_TICK;
                    n_phase     = 1'b0;
                    n_state     = S_MUL_LO;
                end else begin
                    cmd.zero_q = 1'b1;
                    n_state    = S_CLAMP;
                end
            end
            S_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                n_state    = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                n_state    = S_MUL_SUM;
            end
            S_MUL_SUM: begin
                cmd.mul_sum = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = r_phase ? S_RAISE : S_CLAMP;
                end
            end
            S_CLAMP: begin
                cmd.clamp = 1'b1;
                if (i_status.tick_hz_nz) begin
                    cmd.load_op = 1'b1;
                    cmd.op_sel  = OP_DERIVE;
                    n_phase     = 1'b1;
                    n_state     = S_MUL_LO;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RAISE: begin
                cmd.raise = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_cmd     = cmd;
    assign o_m_valid = r_out_valid;

    // A new result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_m_ready))
        else $error("result loaded while output register is occupied");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == S_DISPATCH))
        else $error("accepted item was not dispatched");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_status.div_last) |=>
        (r_state == S_CLAMP || r_state == S_RAISE))
        else $error("divider did not hand over after its last step");

endmodule

>>> src/mnst_dp.sv
module mnst_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [mnst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mnst_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                              i_command,
    input  logic [mnst_pkg::DATA_W-1:0]       i_cycle_count,
    input  mnst_pkg::t_dp_cmd                 i_cmd,
    output mnst_pkg::t_dp_status              o_status,
    output logic [mnst_pkg::DATA_W-1:0]       o_now_ns,
    output logic [mnst_pkg::DATA_W-1:0]       o_tick_count
);
    import mnst_pkg::*;

    logic                 r_enabled;
    logic [TICK_HZ_W-1:0] r_tick_hz;
    logic [CYC_HZ_W-1:0]  r_cycle_hz;
    logic [DATA_W-1:0]    r_cycle_base;
    logic [DATA_W-1:0]    r_tick_total;
    logic [DATA_W-1:0]    r_last_ns;

    logic                 r_cmd;
    logic [DATA_W-1:0]    r_cycles;
    logic [DATA_W-1:0]    r_value;
    logic [MUL_W-1:0]     r_mul;
    logic [DIV_W-1:0]     r_div;
    logic [PP_W-1:0]      r_pp_lo;
    logic [PP_W-1:0]      r_pp_hi;
    logic [PROD_W-1:0]    r_dq;
    logic [DIV_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic [DATA_W-1:0]    r_ns;
    logic [DATA_W-1:0]    r_now_ns;
    logic [DATA_W-1:0]    r_tick_count;

    logic [DIV_W:0]       trial;
    logic                 trial_ge;
    logic [DIV_W-1:0]     n_rem;
    logic [DATA_W-1:0]    q_sat;
    logic [DATA_W-1:0]    ns_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b0;
            r_tick_hz    <= '0;
            r_cycle_hz   <= '0;
            r_cycle_base <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ENABLED:    r_enabled    <= i_cfg_data[0];
                REG_TICK_HZ:    r_tick_hz    <= i_cfg_data[TICK_HZ_W-1:0];
                REG_CYCLE_HZ:   r_cycle_hz   <= i_cfg_data[CYC_HZ_W-1:0];
                REG_CYCLE_BASE: r_cycle_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign trial    = {r_rem, r_dq[PROD_W-1]} - {1'b0, r_div};
    assign trial_ge = !trial[DIV_W];
    assign n_rem    = trial_ge ? trial[DIV_W-1:0] : {r_rem[DIV_W-2:0], r_dq[PROD_W-1]};

    // Quotients of 2^64 or more saturate to all ones.
    assign q_sat      = (|r_dq[PROD_W-1:DATA_W]) ? '1 : r_dq[DATA_W-1:0];
    assign ns_clamped = (q_sat < r_last_ns) ? r_last_ns : q_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_total <= '0;
            r_last_ns    <= '0;
        end else begin
            if (i_cmd.tick && r_enabled) begin
                r_tick_total <= r_tick_total + DATA_W'(1);
            end
            if (i_cmd.clamp) begin
                r_last_ns <= ns_clamped;
            end
            if (i_cmd.raise && (q_sat > r_tick_total)) begin
                r_tick_total <= q_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_command;
            r_cycles <= i_cycle_count;
        end
        if (i_cmd.load_op) begin
            case (i_cmd.op_sel)
                OP_CYCLE: begin
                    r_value <= r_cycles - r_cycle_base;
                    r_mul   <= NS_PER_SEC;
                    r_div   <= r_cycle_hz;
                end
                OP_TICK: begin
                    r_value <= r_tick_total;
                    r_mul   <= NS_PER_SEC;
                    r_div   <= DIV_W'(r_tick_hz);
                end
                OP_DERIVE: begin
                    r_value <= ns_clamped;
                    r_mul   <= MUL_W'(r_tick_hz);
                    r_div   <= DIV_W'(NS_PER_SEC);
                end
                default: begin
                    r_value <= '0;
                    r_mul   <= '0;
                    r_div   <= '0;
                end
            endcase
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= PP_W'(r_value[HALF_W-1:0]) * PP_W'(r_mul);
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= PP_W'(r_value[DATA_W-1:HALF_W]) * PP_W'(r_mul);
        end
        if (i_cmd.zero_q) begin
            r_dq <= '0;
        end else if (i_cmd.mul_sum) begin
            r_dq <= PROD_W'(r_pp_lo) + {r_pp_hi, {HALF_W{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_dq <= {r_dq[PROD_W-2:0], trial_ge};
        end
        if (i_cmd.mul_sum) begin
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.clamp) begin
            r_ns <= ns_clamped;
        end
        if (i_cmd.load_out) begin
            r_now_ns     <= (r_cmd && r_enabled) ? r_ns : '0;
            r_tick_count <= (!r_cmd || r_enabled) ? r_tick_total : '0;
        end
    end

    assign o_status.cmd_read    = r_cmd;
    assign o_status.enabled     = r_enabled;
    assign o_status.cycle_hz_nz = (r_cycle_hz != '0);
    assign o_status.tick_hz_nz  = (r_tick_hz != '0);
    assign o_status.div_last    = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign o_now_ns     = r_now_ns;
    assign o_tick_count = r_tick_count;

    a_last_ns_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_last_ns >= $past(r_last_ns)))
        else $error("last returned time went backward");

endmodule

>>> src/monotonic_ns_timebase.sv
// Monotonic nanosecond timebase. An input item with tuser set is a time read: it converts the
// elapsed cycle count (tdata minus the configured base) to nanoseconds through the cycle
// frequency, or the tick count through the tick frequency when no cycle frequency is set,
// never returns less than the previous read, and raises the tick count to match. An item with
// tuser clear is a timer tick. Every item yields one result item. Conversions share one
// restoring divider that produces one quotient bit per cycle over a 94-bit product. A tick or
// a disabled read goes from dispatch straight to the result, and a read with no frequency set
// at all passes through the clamp step first. A read with a cycle frequency and no tick rate
// runs the divider once; with a tick rate set it runs twice, once for the time conversion
// and once more for the tick count update. A new item can be accepted in the cycle after the
// result is loaded, and a result not yet taken holds the block before the next is loaded. The
// user must see that registers are written only while idle; the block does not enforce it.
module monotonic_ns_timebase (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mnst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mnst_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mnst_pkg::DATA_W-1:0]    s_tdata,   // cycle_count
    input  logic [0:0]                     s_tuser,   // command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*mnst_pkg::DATA_W-1:0]  m_tdata    // now_ns, tick_count
);
    import mnst_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [DATA_W-1:0] now_ns;
    logic [DATA_W-1:0] tick_count;

    assign o_cfg_ready = 1'b1;

    mnst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_m_ready (m_tready),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_s_ready (s_tready),
        .o_m_valid (m_tvalid)
    );

    mnst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (s_tuser[0]),
        .i_cycle_count (s_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_now_ns      (now_ns),
        .o_tick_count  (tick_count)
    );

    assign m_tdata = {tick_count, now_ns};

endmodule

>>> dv/mnst_checker.sv
`timescale 1ns / 1ps

module mnst_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mnst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mnst_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [mnst_pkg::DATA_W-1:0]    i_s_tdata,   // cycle_count
    input  logic [0:0]                     i_s_tuser,   // command
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [2*mnst_pkg::DATA_W-1:0]  i_m_tdata,   // now_ns, tick_count
    output int                             o_mismatches,
    output int                             o_pending
);

    import mnst_pkg::*;

    localparam logic [63:0] NS_IN_SEC = 64'd1_000_000_000;
    localparam logic [63:0] ALL_ONES  = '1;

    typedef struct packed {
        logic [63:0] now_ns;
        logic [63:0] tick_count;
    } t_time_result;

    logic [63:0]  en_reg;
    logic [63:0]  tick_hz_reg;
    logic [63:0]  cycle_hz_reg;
    logic [63:0]  cycle_base_reg;
    logic [63:0]  tick_total;
    logic [63:0]  last_ns;
    t_time_result expected_times[$];
    int           mismatch_count;

    // Saturating value * mul / div, split into quotient and remainder parts.
    function automatic logic [63:0] scale_sat(input logic [63:0] value, input logic [63:0] mul,
                                              input logic [63:0] div);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] hi;
        logic [63:0] lo;
        if (div == 64'd0) return ALL_ONES;
        if (mul == 64'd0) return 64'd0;
        q = value / div;
        r = value % div;
        if (q > ALL_ONES / mul) return ALL_ONES;
        hi = q * mul;
        lo = (r * mul) / div;
        if (hi > ALL_ONES - lo) return ALL_ONES;
        return hi + lo;
    endfunction

    function automatic t_time_result advance_timebase(input logic is_read,
                                                      input logic [63:0] cycles);
        t_time_result res;
        logic [63:0]  ns;
        logic [63:0]  derived;
        res = '0;
        if (!is_read) begin
            if (en_reg[0]) tick_total = tick_total + 64'd1;
            res.tick_count = tick_total;
            return res;
        end
        if (!en_reg[0]) return res;
        if (cycle_hz_reg != 64'd0) begin
            ns = scale_sat(cycles - cycle_base_reg, NS_IN_SEC, cycle_hz_reg);
        end else if (tick_hz_reg != 64'd0) begin
            ns = scale_sat(tick_total, NS_IN_SEC, tick_hz_reg);
        end else begin
            ns = 64'd0;
        end
        if (ns < last_ns) ns = last_ns;
        else last_ns = ns;
        if (tick_hz_reg != 64'd0) begin
            derived = scale_sat(ns, tick_hz_reg, NS_IN_SEC);
            if (derived > tick_total) tick_total = derived;
        end
        res.now_ns     = ns;
        res.tick_count = tick_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_time_result want;
        logic [63:0]  got_ns;
        logic [63:0]  got_ticks;
        if (!i_rst_n) begin
            en_reg         = '0;
            tick_hz_reg    = '0;
            cycle_hz_reg   = '0;
            cycle_base_reg = '0;
            tick_total     = '0;
            last_ns        = '0;
            mismatch_count = 0;
            expected_times.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_ENABLED:    en_reg         = {63'd0, i_cfg_data[0]};
                    REG_TICK_HZ:    tick_hz_reg    = {44'd0, i_cfg_data[TICK_HZ_W-1:0]};
                    REG_CYCLE_HZ:   cycle_hz_reg   = {30'd0, i_cfg_data[CYC_HZ_W-1:0]};
                    REG_CYCLE_BASE: cycle_base_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got_ns    = i_m_tdata[63:0];
                got_ticks = i_m_tdata[127:64];
                if (expected_times.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected item now_ns=%h tick_count=%h",
                             $time, got_ns, got_ticks);
                end else begin
                    want = expected_times.pop_front();
                    if (got_ns !== want.now_ns) begin
                        mismatch_count++;
                        $display("%0t: now_ns expected %h actual %h",
                                 $time, want.now_ns, got_ns);
                    end
                    if (got_ticks !== want.tick_count) begin
                        mismatch_count++;
                        $display("%0t: tick_count expected %h actual %h",
                                 $time, want.tick_count, got_ticks);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_times.push_back(advance_timebase(i_s_tuser[0], i_s_tdata));
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_times.size();
    end

endmodule

>>> dv/tb_monotonic_ns_timebase.sv
`timescale 1ns / 1ps

module tb_monotonic_ns_timebase;

    import mnst_pkg::*;

    localparam logic        CMD_TICK       = 1'b0;
    localparam logic        CMD_READ       = 1'b1;
    localparam logic [63:0] TICK_HZ_MAX    = 64'd1_000_000;
    localparam logic [63:0] CYCLE_HZ_MAX   = 64'h3_FFFF_FFFF;
    localparam logic [63:0] NS_IN_SEC      = 64'd1_000_000_000;
    localparam int          RX_HOLD_CYCLES = 3000;
    localparam int          RANDOM_ITEMS   = 1200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [2*DATA_W-1:0]   m_tdata;

    int                    mismatches;
    int                    pending;
    bit                    rx_hold_req;
    int                    burst_left;
    logic [63:0]           cur_cycle_hz;
    logic [63:0]           cur_base;
    logic [63:0]           wall_sec;
    logic [63:0]           wall_frac;

    monotonic_ns_timebase u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    mnst_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // The result side alternates between always ready, random and mostly stalled stretches.
    initial begin
        int seg_len;
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            seg_len = $urandom_range(1, 64);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
                @(negedge i_clk);
                if (rx_hold_req && !hold_done) begin
                    hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic en, input logic [63:0] thz, input logic [63:0] chz,
                             input logic [63:0] base);
        write_reg(REG_ENABLED, {63'd0, en});
        write_reg(REG_TICK_HZ, thz);
        write_reg(REG_CYCLE_HZ, chz);
        write_reg(REG_CYCLE_BASE, base);
        i_cfg_valid  <= 1'b0;
        cur_cycle_hz = chz;
        cur_base     = base;
    endtask

    task automatic send_item(input logic cmd, input logic [63:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Reads follow a wall clock that only moves forward, so the returned time keeps growing
    // across settings; now and then the counter steps back a little.
    task automatic send_read();
        logic [63:0] offset;
        if ($urandom_range(0, 15) == 0) begin
            wall_sec = wall_sec + 64'($urandom_range(1, 100000));
        end else begin
            wall_frac = wall_frac + 64'($urandom_range(0, 2_000_000));
            if (wall_frac >= NS_IN_SEC) begin
                wall_frac = wall_frac - NS_IN_SEC;
                wall_sec  = wall_sec + 64'd1;
            end
        end
        if (cur_cycle_hz == 64'd0) begin
            send_item(CMD_READ, {$urandom, $urandom});
        end else begin
            offset = wall_sec * cur_cycle_hz + (wall_frac * cur_cycle_hz) / NS_IN_SEC;
            if ($urandom_range(0, 7) == 0 && offset > 64'd1000) begin
                offset = offset - 64'($urandom_range(1, 1000));
            end else begin
                offset = offset + 64'($urandom_range(0, 3));
            end
            send_item(CMD_READ, cur_base + offset);
        end
    endtask

    initial begin
        int          phase;
        int          phase_items;
        int          sent;
        logic        en;
        logic [63:0] thz;
        logic [63:0] chz;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_ENABLED;
        i_cfg_data   = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_TICK;
        rx_hold_req  = 1'b0;
        burst_left   = 0;
        cur_cycle_hz = '0;
        cur_base     = '0;
        wall_sec     = 64'd2;
        wall_frac    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Disabled after reset: ticks are ignored and reads return zeros.
        send_item(CMD_TICK, '1);
        send_item(CMD_READ, '1);
        send_item(CMD_READ, '0);
        settle();

        // No frequency at all: the raw time is zero and the tick count is left alone.
        configure(1'b1, 64'd0, 64'd0, 64'd0);
        send_item(CMD_TICK, '0);
        send_item(CMD_TICK, '1);
        send_item(CMD_READ, 64'd12345);
        settle();

        // Tick fallback at a tick rate of 1 MHz.
        configure(1'b1, TICK_HZ_MAX, 64'd0, 64'd0);
        send_item(CMD_TICK, '0);
        send_item(CMD_READ, '1);
        send_item(CMD_TICK, '0);
        send_item(CMD_READ, '0);
        settle();

        // Highest cycle rate; the counter wraps past zero while the difference stays small.
        configure(1'b1, 64'd1, CYCLE_HZ_MAX, 64'hFFFF_FFFF_FFFF_0000);
        send_item(CMD_READ, 64'hFFFF_FFFF_FFFF_0000 + CYCLE_HZ_MAX);
        send_item(CMD_READ, 64'hFFFF_FFFF_FFFF_0000 + 64'd5);
        send_item(CMD_TICK, '0);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            en = ($urandom_range(0, 5) != 0);
            case ($urandom_range(0, 3))
                0: thz = 64'd0;
                1: thz = 64'd1;
                2: thz = TICK_HZ_MAX;
                default: thz = 64'($urandom_range(1, 1_000_000));
            endcase
            case ($urandom_range(0, 3))
                0: chz = 64'd0;
                1: chz = 64'($urandom_range(1, 1000));
                2: chz = CYCLE_HZ_MAX;
                default: chz = {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)} | 64'd1;
            endcase
            configure(en, thz, chz, {$urandom, $urandom});
            if (phase == 2) rx_hold_req = 1'b1;
            phase_items = $urandom_range(60, 140);
            repeat (phase_items) begin
                if ($urandom_range(0, 1) == 0) send_item(CMD_TICK, {$urandom, $urandom});
                else send_read();
            end
            sent += phase_items;
            phase++;
            settle();
        end

        // Conversion overflow: the counter is behind the base, so the difference wraps huge.
        configure(1'b1, TICK_HZ_MAX, 64'd1, 64'd1);
        send_item(CMD_READ, '0);
        send_item(CMD_READ, '1);
        send_item(CMD_TICK, '0);
        settle();
        configure(1'b1, 64'd7, 64'd0, 64'd0);
        send_item(CMD_READ, '0);
        settle();
        configure(1'b0, 64'd7, 64'd0, 64'd0);
        send_item(CMD_READ, '1);
        send_item(CMD_TICK, '1);
        settle();

        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> monotonic_ns_timebase.f
src/mnst_pkg.sv
src/mnst_ctrl.sv
src/mnst_dp.sv
src/monotonic_ns_timebase.sv
dv/mnst_checker.sv
dv/tb_monotonic_ns_timebase.sv
